// ----- rtl/core/fut_pkg.sv -----
// ----------------------------------------------------------------------------
// fut_pkg
// Shared types and sizes for the first-unique tracker: store geometry,
// sequencer states and the control/status bundles between its modules.
// ----------------------------------------------------------------------------
package fut_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int ENTRY_W     = VALUE_WIDTH + 1;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [ENTRY_W-1:0]     entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Sequencer to compare unit
  typedef struct packed {
    logic clear;
    logic step;
  } match_ctl_t;

  // Compare unit back to sequencer
  typedef struct packed {
    logic   match;
    logic   hit;
    logic   found;
    value_t first_value;
  } match_sts_t;

  // One result item
  typedef struct packed {
    value_t first_value;
    logic   found;
    logic   dropped;
  } result_t;

endpackage

// ----- rtl/core/fut_if.sv -----
// ----------------------------------------------------------------------------
// fut_if
// Valid/ready channel interfaces for the tracker's input and result streams.
// ----------------------------------------------------------------------------
interface fut_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

interface fut_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_value;
  logic               found;
  logic               dropped;

  modport source (output valid, output first_value, output found, output dropped,
                  input ready);
  modport sink   (input valid, input first_value, input found, input dropped,
                  output ready);
endinterface

// ----- rtl/core/fut_ram.sv -----
// ----------------------------------------------------------------------------
// fut_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/fut_match.sv -----
// ----------------------------------------------------------------------------
// fut_match
// Shared compare unit: matches one stored entry per step against the key
// and tracks the hit and the earliest entry left unmarked.
// ----------------------------------------------------------------------------
module fut_match import fut_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  match_ctl_t ctl,
  input  value_t     key,
  input  value_t     ent_value,
  input  logic       ent_mark,
  output match_sts_t sts
);

  logic   hit_r, hit_nxt;
  logic   found_r, found_nxt;
  value_t first_r, first_nxt;
  logic   match;

  assign match = (ent_value == key);

  // Accumulate hit and first unmarked entry; a matching entry counts as marked
  always_comb begin
    hit_nxt   = hit_r;
    found_nxt = found_r;
    first_nxt = first_r;
    if (ctl.clear) begin
      hit_nxt   = 1'b0;
      found_nxt = 1'b0;
    end else if (ctl.step) begin
      hit_nxt = hit_r | match;
      if (!found_r && !(ent_mark | match)) begin
        found_nxt = 1'b1;
        first_nxt = ent_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
    end
    first_r <= first_nxt;
  end

  assign sts.match       = match;
  assign sts.hit         = hit_r;
  assign sts.found       = found_r;
  assign sts.first_value = first_r;

endmodule

// ----- rtl/core/fut_ctrl.sv -----
// ----------------------------------------------------------------------------
// fut_ctrl
// Sequencer: takes an item, walks the stored entries through the compare
// unit, writes back marks, appends new values and forms the result.
// ----------------------------------------------------------------------------
module fut_ctrl import fut_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  value_t     in_value,
  input  logic       in_restart,
  input  logic       out_free,
  output logic       res_load,
  output result_t    res,
  input  match_sts_t sts,
  output match_ctl_t mctl,
  output value_t     key,
  output logic       ram_we,
  output addr_t      ram_waddr,
  output entry_t     ram_wdata,
  output addr_t      ram_raddr
);

  state_t state_r, state_nxt;
  count_t fill_r, fill_nxt;
  count_t rd_idx_r, rd_idx_nxt;
  logic   pend_r, pend_nxt;
  addr_t  data_idx_r, data_idx_nxt;
  value_t val_r, val_nxt;
  logic   issue;
  logic   has_room;

  assign issue     = (rd_idx_r < fill_r);
  assign has_room  = (fill_r < count_t'(STORE_DEPTH));
  assign key       = val_r;
  assign ram_raddr = rd_idx_r[ADDR_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !pend_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath register updates
  always_comb begin
    in_ready        = 1'b0;
    res_load        = 1'b0;
    res             = '0;
    mctl            = '0;
    ram_we          = 1'b0;
    ram_waddr       = data_idx_r;
    ram_wdata       = {1'b1, val_r};
    fill_nxt        = fill_r;
    rd_idx_nxt      = rd_idx_r;
    pend_nxt        = pend_r;
    data_idx_nxt    = data_idx_r;
    val_nxt         = val_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt    = in_value;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          mctl.clear = 1'b1;
          if (in_restart) fill_nxt = '0;
        end
      end
      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        pend_nxt = issue;
        if (issue) begin
          rd_idx_nxt   = rd_idx_r + count_t'(1);
          data_idx_nxt = rd_idx_r[ADDR_W-1:0];
        end
        if (pend_r) begin
          mctl.step = 1'b1;
          if (sts.match) begin
            ram_we = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          res_load        = 1'b1;
          res.found       = sts.found;
          res.first_value = sts.found ? sts.first_value : '0;
          if (!sts.hit) begin
            if (has_room) begin
              // append the new value unmarked
              ram_we    = 1'b1;
              ram_waddr = fill_r[ADDR_W-1:0];
              ram_wdata = {1'b0, val_r};
              fill_nxt  = fill_r + count_t'(1);
              if (!sts.found) begin
                res.found       = 1'b1;
                res.first_value = val_r;
              end
            end else begin
              res.dropped = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    data_idx_r <= data_idx_nxt;
    val_r      <= val_nxt;
  end

endmodule

// ----- rtl/core/first_unique_tracker.sv -----
// ----------------------------------------------------------------------------
// first_unique_tracker
// Reports the earliest value seen exactly once in a stream of values.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one value per transfer; restart empties the store first.
//   out_chan returns exactly one result per input transfer: the earliest
//   value seen only once (found = 1), or found = 0 and first_value = 0, plus
//   dropped = 1 when a new value did not fit in the full store.
//   The sequencer walks all N entries held (after any restart, at most
//   STORE_DEPTH) through one compare unit, one entry per cycle off the
//   RAM read port. in_chan.ready is high only in the idle state, so items
//   are taken one at a time. The result sits in an output register; the
//   next item is accepted while it waits. If out_chan stalls, the
//   following item holds in its final step until the register frees.
//   Reset (rst_n low, synchronous) empties the store by clearing the fill
//   count; the RAM needs no clearing pass, and the block is ready at once.
// ----------------------------------------------------------------------------
module first_unique_tracker import fut_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fut_in_if.sink    in_chan,
  fut_out_if.source out_chan
);

  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r, out_res_nxt;
  logic       out_free;
  logic       res_load;
  result_t    res;
  match_sts_t sts;
  match_ctl_t mctl;
  value_t     key;
  logic       ram_we;
  addr_t      ram_waddr;
  entry_t     ram_wdata;
  addr_t      ram_raddr;
  entry_t     ram_rdata;

  assign out_free = !out_valid_r || out_chan.ready;

  fut_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_value   (value_t'(in_chan.value)),
    .in_restart (in_chan.restart),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .sts        (sts),
    .mctl       (mctl),
    .key        (key),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr)
  );

  fut_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mctl),
    .key       (key),
    .ent_value (ram_rdata[VALUE_WIDTH-1:0]),
    .ent_mark  (ram_rdata[ENTRY_W-1]),
    .sts       (sts)
  );

  // Store: {repeated mark, value} per entry
  fut_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold the result until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.first_value = out_res_r.first_value;
  assign out_chan.found       = out_res_r.found;
  assign out_chan.dropped     = out_res_r.dropped;

endmodule

// ----- verif/tb_first_unique_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_first_unique_tracker
// Self-checking bench for the first-unique tracker. A directed table covers
// extremes, repeats, restarts and the no-unique case. A store-full pass
// fills every entry and then offers new values that must be dropped. Random
// streams over small value pools follow. Every result is compared with its
// typed row's answer or an in-bench tracker; both channels stall at random.
// ----------------------------------------------------------------------------
module tb_first_unique_tracker;
  import fut_pkg::*;

  localparam int          RANDOM_ITEMS = 580;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          SETTLE_WAIT  = STORE_DEPTH + 80;
  localparam int          MAX_REPORTS  = 30;
  localparam int          DIR_ROWS     = 25;

  // One row of the directed table; typed rows carry their own answer
  typedef struct packed {
    value_t value;
    logic   restart;
    logic   typed;
    value_t exp_value;
    logic   exp_found;
    logic   exp_dropped;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fut_in_if  in_chan ();
  fut_out_if out_chan ();

  first_unique_tracker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Tracker copy of the store
  value_t      seen_vals  [STORE_DEPTH];
  bit          seen_twice [STORE_DEPTH];
  int          held_count = 0;

  result_t     pending_results [$];
  int          mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  bit          quiet           = 1'b0;
  int          stall_left      = 0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'h5555_5554, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0}
  };

  // Clock: period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Add one value to the tracked store and return the expected result
  function automatic result_t track_first_unique(value_t v, bit clear_first);
    result_t res;
    bit      hit;
    int      idx;
    res = '0;
    hit = 1'b0;
    if (clear_first) held_count = 0;
    for (idx = 0; idx < held_count; idx++) begin
      if (!hit && seen_vals[idx] == v) begin
        seen_twice[idx] = 1'b1;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (held_count < STORE_DEPTH) begin
        seen_vals[held_count]  = v;
        seen_twice[held_count] = 1'b0;
        held_count++;
      end else begin
        res.dropped = 1'b1;
      end
    end
    // Walk backward so the earliest unmarked entry wins
    for (idx = held_count - 1; idx >= 0; idx--) begin
      if (!seen_twice[idx]) begin
        res.first_value = seen_vals[idx];
        res.found       = 1'b1;
      end
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet)  return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Fresh value: extremes, small numbers or full-width random
  function automatic value_t pick_fresh();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    if (r < 3) return value_t'($urandom_range(0, 15));
    return value_t'($urandom);
  endfunction

  // Offer one item after a random gap; log its expectation on transfer
  task automatic send_value(input value_t v, input bit clear_first, input bit typed,
                            input result_t typed_res);
    int      gap;
    result_t exp_res;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid   <= 1'b0;
      in_chan.value   <= $urandom;
      in_chan.restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.value   <= v;
    in_chan.restart <= clear_first;
    do @(posedge clk); while (!in_chan.ready);
    exp_res = track_first_unique(v, clear_first);
    if (typed) exp_res = typed_res;
    pending_results.push_back(exp_res);
  endtask

  // Hold the sender until every result is back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result channel: random stalls, with quiet stretches
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result first_value=%h found=%b dropped=%b", $time,
                   out_chan.first_value, out_chan.found, out_chan.dropped);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_chan.first_value !== exp_res.first_value ||
            out_chan.found !== exp_res.found || out_chan.dropped !== exp_res.dropped) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                     exp_res.first_value, exp_res.found, exp_res.dropped,
                     out_chan.first_value, out_chan.found, out_chan.dropped);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    result_t row_res;
    value_t  fill_base;
    value_t  spill_value;
    value_t  pool [8];
    int      sent;
    int      len;
    int      pool_n;
    int      k;
    int      r;
    bit      clear_first;

    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.value   = '0;
    in_chan.restart = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (k = 0; k < DIR_ROWS; k++) begin
      row_res.first_value = directed_rows[k].exp_value;
      row_res.found       = directed_rows[k].exp_found;
      row_res.dropped     = directed_rows[k].exp_dropped;
      send_value(directed_rows[k].value, directed_rows[k].restart,
                 directed_rows[k].typed, row_res);
    end
    drain_results();

    // Fill the store, then offer values that no longer fit
    fill_base = $urandom;
    send_value(fill_base, 1'b1, 1'b0, '0);
    for (k = 1; k < STORE_DEPTH; k++) begin
      send_value(fill_base + value_t'(k), 1'b0, 1'b0, '0);
      if (k % 100 == 0)
        send_value(fill_base + value_t'($urandom_range(0, k - 1)), 1'b0, 1'b0, '0);
    end
    spill_value = fill_base + value_t'(STORE_DEPTH + 4096);
    send_value(spill_value, 1'b0, 1'b0, '0);
    send_value(fill_base, 1'b0, 1'b0, '0);
    send_value(spill_value, 1'b0, 1'b0, '0);
    send_value(fill_base + value_t'(STORE_DEPTH - 1), 1'b0, 1'b0, '0);
    send_value(~spill_value, 1'b0, 1'b0, '0);
    drain_results();

    // Random streams over small pools, with some noise and broken streams
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet  = ($urandom_range(0, 7) == 0);
      len    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(20, 60);
      pool_n = $urandom_range(1, (len < 8) ? len : 8);
      for (k = 0; k < pool_n; k++) begin
        if (k > 0 && $urandom_range(0, 3) == 0)
          pool[k] = pool[k - 1] ^ (value_t'(1) << $urandom_range(0, VALUE_WIDTH - 1));
        else
          pool[k] = pick_fresh();
      end
      // Occasionally carry on from the previous stream while the store is small
      clear_first = !(held_count < 64 && $urandom_range(0, 9) == 0);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 85)
          send_value(pool[$urandom_range(0, pool_n - 1)], clear_first, 1'b0, '0);
        else if (r < 95)
          send_value(pick_fresh(), clear_first, 1'b0, '0);
        else
          send_value(pool[$urandom_range(0, pool_n - 1)], 1'b1, 1'b0, '0);
        clear_first = 1'b0;
        sent++;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    quiet = 1'b0;

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- first_unique_tracker.f -----
rtl/core/fut_pkg.sv
rtl/core/fut_if.sv
rtl/core/fut_ram.sv
rtl/core/fut_match.sv
rtl/core/fut_ctrl.sv
rtl/core/first_unique_tracker.sv
verif/tb_first_unique_tracker.sv
